// File: rtl/core/mke_pkg.sv
// mke_pkg: shared types, codes and constants of the morse keying encoder
// no dependencies; imported by the request channel interface and every core module
package mke_pkg;

	localparam int DEF_TABLE_ENTRIES = 128;
	localparam int DEF_MAX_SYMBOLS = 5;
	localparam int PATTERN_BITS = 5;
	localparam int COUNT_BITS = 3;
	localparam int CODE_BITS = 8;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_ENCODE = 1'b1;

	localparam logic [CODE_BITS-1:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [CODE_BITS-1:0] CHAR_SPACE = 8'h20;

	localparam logic [2:0] CLOSE_GAP = 3'd2;
	localparam logic [2:0] SPACE_GAP = 3'd4;

	localparam logic [1:0] DAH_LAST_PHASE = 2'd3;
	localparam logic [1:0] DIT_LAST_PHASE = 2'd1;

	typedef struct packed {
		logic [COUNT_BITS-1:0]   len;
		logic [PATTERN_BITS-1:0] pat;
	} mke_entry_t;

	typedef struct packed {
		logic                    line_break;
		logic [COUNT_BITS-1:0]   sym_count;
		logic [PATTERN_BITS-1:0] pattern;
		logic [2:0]              gap_count;
	} mke_start_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} mke_state_t;

endpackage

// File: rtl/core/mke_channels.sv
// mke_channels: valid/ready channel interfaces for requests and keying units
// depends on mke_pkg for field widths
interface mke_req_if
	import mke_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic                    cmd;
	logic [CODE_BITS-1:0]    char_code;
	logic [PATTERN_BITS-1:0] pattern;
	logic [COUNT_BITS-1:0]   pattern_len;

	modport source (output valid, input ready, output cmd, char_code, pattern, pattern_len);
	modport sink (input valid, output ready, input cmd, char_code, pattern, pattern_len);
endinterface

interface mke_unit_if;
	logic valid;
	logic ready;
	logic key_on;
	logic line_break;
	logic last_unit;

	modport source (output valid, input ready, output key_on, line_break, last_unit);
	modport sink (input valid, output ready, input key_on, line_break, last_unit);
endinterface

// File: rtl/core/mke_table.sv
// mke_table: symbol table memory with per-entry valid bits, registered read
// depends on mke_pkg; entries never written read back as zero
module mke_table
	import mke_pkg::*;
#(
	parameter int ENTRIES = DEF_TABLE_ENTRIES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [$clog2(ENTRIES)-1:0] wr_addr,
	input  mke_entry_t                 wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(ENTRIES)-1:0] rd_addr,
	output mke_entry_t                 rd_data
);

	mke_entry_t         mem_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	mke_entry_t         rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem_q[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/mke_serializer.sv
// mke_serializer: shifts pattern bits out one keying unit per unstalled cycle
// depends on mke_pkg and mke_channels; output register decouples the receiver
module mke_serializer
	import mke_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start_valid,
	input  mke_start_t start,
	output logic       busy,
	mke_unit_if.source keying
);

	logic                    brk_pend_q;
	logic [COUNT_BITS-1:0]   sym_left_q;
	logic [PATTERN_BITS-1:0] pat_q;
	logic [1:0]              phase_q;
	logic [2:0]              gap_left_q;
	logic                    out_valid_q;
	logic                    out_key_q;
	logic                    out_brk_q;
	logic                    out_last_q;

	logic gen_active;
	logic advance;
	logic dah;
	logic sym_end;
	logic next_key;
	logic next_brk;
	logic next_last;

	assign gen_active = brk_pend_q | (sym_left_q != '0) | (gap_left_q != '0);
	assign busy = gen_active;
	assign advance = gen_active & (~out_valid_q | keying.ready);
	assign dah = pat_q[0];
	assign sym_end = dah ? (phase_q == DAH_LAST_PHASE) : (phase_q == DIT_LAST_PHASE);

	always_comb begin
		next_key = 1'b0;
		next_brk = 1'b0;
		next_last = 1'b0;
		if (brk_pend_q) begin
			next_brk = 1'b1;
			next_last = 1'b1;
		end else if (sym_left_q != '0) begin
			next_key = ~sym_end;
		end else begin
			next_last = (gap_left_q == 3'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brk_pend_q <= 1'b0;
			sym_left_q <= '0;
			phase_q <= '0;
			gap_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (start_valid) begin
				brk_pend_q <= start.line_break;
				sym_left_q <= start.sym_count;
				phase_q <= '0;
				gap_left_q <= start.gap_count;
			end else if (advance) begin
				if (brk_pend_q) begin
					brk_pend_q <= 1'b0;
				end else if (sym_left_q != '0) begin
					if (sym_end) begin
						phase_q <= '0;
						sym_left_q <= sym_left_q - 1'b1;
					end else begin
						phase_q <= phase_q + 1'b1;
					end
				end else begin
					gap_left_q <= gap_left_q - 1'b1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (keying.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_valid) begin
			pat_q <= start.pattern;
		end else if (advance && !brk_pend_q && sym_left_q != '0 && sym_end) begin
			pat_q <= pat_q >> 1;
		end
		if (advance) begin
			out_key_q <= next_key;
			out_brk_q <= next_brk;
			out_last_q <= next_last;
		end
	end

	assign keying.valid = out_valid_q;
	assign keying.key_on = out_key_q;
	assign keying.line_break = out_brk_q;
	assign keying.last_unit = out_last_q;

endmodule

// File: rtl/core/morse_keying_encoder.sv
// morse_keying_encoder: top level, request decode, table lookup and keying output
// depends on mke_pkg, mke_channels, mke_table and mke_serializer
//
// usage:
// - request channel: cmd load writes pattern and pattern_len into the table
//   at char_code (ignored at or above the table size, length saturated);
//   cmd encode turns char_code into keying units
// - keying channel: one unit per transfer, key_on is the tone level,
//   line_break marks a newline, last_unit closes each character
// - an encode reads the table, loads the shifter from the registered read,
//   then sends one unit per cycle while the receiver is ready
// - a character gives 1 to 22 units; the single shifter sets the pace, as a
//   new request waits until the shifter has generated every unit
// - the next request is taken while the final unit still sits in the
//   output register
// - reset clears every table entry at once through per-entry valid bits;
//   no sweep follows reset
// - a stalled receiver holds the current unit and freezes the shifter
module morse_keying_encoder
	import mke_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
	input  logic      clk,
	input  logic      arst_n,
	mke_req_if.sink   request,
	mke_unit_if.source keying
);

	localparam int AddrBits = $clog2(TABLE_ENTRIES);
	localparam int LenCap = (MAX_SYMBOLS > PATTERN_BITS) ? PATTERN_BITS : MAX_SYMBOLS;

	mke_state_t state_q;
	mke_state_t state_d;

	logic                 ser_busy;
	logic                 accept;
	logic                 in_range;
	logic                 wr_en;
	logic                 rd_en;
	logic [AddrBits-1:0]  addr;
	mke_entry_t           wr_data;
	mke_entry_t           rd_data;
	logic [CODE_BITS-1:0] code_q;
	logic                 in_range_q;
	logic                 start_valid;
	mke_start_t           start;

	assign request.ready = (state_q == ST_IDLE) & ~ser_busy;
	assign accept = request.valid & request.ready;
	assign in_range = {1'b0, request.char_code} < (CODE_BITS + 1)'(TABLE_ENTRIES);
	assign addr = request.char_code[AddrBits-1:0];
	assign wr_en = accept & (request.cmd == CMD_LOAD) & in_range;
	assign rd_en = accept & (request.cmd == CMD_ENCODE);
	assign wr_data.pat = request.pattern;
	assign wr_data.len = (request.pattern_len > COUNT_BITS'(LenCap)) ?
		COUNT_BITS'(LenCap) : request.pattern_len;

	mke_table #(
		.ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			code_q <= request.char_code;
			in_range_q <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		start_valid = 1'b0;
		start = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (rd_en) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				start_valid = 1'b1;
				state_d = ST_IDLE;
				if (code_q == CHAR_NEWLINE) begin
					start.line_break = 1'b1;
				end else if (code_q == CHAR_SPACE) begin
					start.gap_count = SPACE_GAP;
				end else begin
					start.gap_count = CLOSE_GAP;
					if (in_range_q) begin
						start.sym_count = rd_data.len;
						start.pattern = rd_data.pat;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	mke_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_valid (start_valid),
		.start       (start),
		.busy        (ser_busy),
		.keying      (keying)
	);

endmodule

// File: tb/sv/morse_keying_encoder_tb.sv
`timescale 1ns / 100ps
// morse_keying_encoder_tb: directed table then random load/encode requests, with every
// keying unit checked against listed units or a local copy of the symbol table; needs
// mke_pkg, mke_channels and the morse_keying_encoder rtl
module morse_keying_encoder_tb;
	import mke_pkg::*;

	localparam int LEN_CAP = (DEF_MAX_SYMBOLS < PATTERN_BITS) ? DEF_MAX_SYMBOLS : PATTERN_BITS;
	localparam int RANDOM_REQUESTS = 280;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic key_on;
		logic line_break;
		logic last_unit;
	} key_unit_t;

	typedef struct {
		logic                    cmd;
		logic [CODE_BITS-1:0]    code;
		logic [PATTERN_BITS-1:0] pat;
		logic [COUNT_BITS-1:0]   len;
		int                      n_units;
		logic [21:0]             keys;
		logic                    brk;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	mke_req_if req_ch();
	mke_unit_if unit_ch();

	morse_keying_encoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_ch),
		.keying(unit_ch)
	);

	always #5 clk = ~clk;

	mke_entry_t sym_entries [DEF_TABLE_ENTRIES];
	key_unit_t pending_units [$];
	stim_row_t directed_rows [$];
	int error_count = 0;
	bit quiet = 1'b0;

	function automatic void push_unit(logic key, logic brk);
		key_unit_t u;
		u.key_on = key;
		u.line_break = brk;
		u.last_unit = 1'b0;
		pending_units.push_back(u);
	endfunction

	function automatic void load_symbol(logic [CODE_BITS-1:0] code,
			logic [PATTERN_BITS-1:0] pat, logic [COUNT_BITS-1:0] len);
		mke_entry_t e;
		e.pat = pat;
		e.len = (len > LEN_CAP) ? COUNT_BITS'(LEN_CAP) : len;
		if (code < DEF_TABLE_ENTRIES)
			sym_entries[code[6:0]] = e;
	endfunction

	function automatic void expect_char(logic [CODE_BITS-1:0] code);
		mke_entry_t e;
		int cnt;
		if (code == CHAR_NEWLINE) begin
			push_unit(1'b0, 1'b1);
		end else if (code == CHAR_SPACE) begin
			repeat (SPACE_GAP) push_unit(1'b0, 1'b0);
		end else begin
			e = '0;
			if (code < DEF_TABLE_ENTRIES)
				e = sym_entries[code[6:0]];
			cnt = (e.len > LEN_CAP) ? LEN_CAP : e.len;
			for (int j = 0; j < cnt; j++) begin
				if (e.pat[j]) begin
					repeat (3) push_unit(1'b1, 1'b0);
					push_unit(1'b0, 1'b0);
				end else begin
					push_unit(1'b1, 1'b0);
					push_unit(1'b0, 1'b0);
				end
			end
			repeat (CLOSE_GAP) push_unit(1'b0, 1'b0);
		end
		pending_units[pending_units.size()-1].last_unit = 1'b1;
	endfunction

	function automatic void expect_units(int n, logic [21:0] keys, logic brk);
		for (int k = 0; k < n; k++)
			push_unit(keys[k], brk);
		pending_units[pending_units.size()-1].last_unit = 1'b1;
	endfunction

	function automatic void add_row(logic cmd, int code, int pat, int len, int n,
			logic [21:0] keys, logic brk);
		stim_row_t r;
		r.cmd = cmd;
		r.code = CODE_BITS'(code);
		r.pat = PATTERN_BITS'(pat);
		r.len = COUNT_BITS'(len);
		r.n_units = n;
		r.keys = keys;
		r.brk = brk;
		directed_rows.push_back(r);
	endfunction

	function automatic stim_row_t make_row(logic cmd, int code, int pat, int len);
		stim_row_t r;
		r.cmd = cmd;
		r.code = CODE_BITS'(code);
		r.pat = PATTERN_BITS'(pat);
		r.len = COUNT_BITS'(len);
		r.n_units = -1;
		r.keys = '0;
		r.brk = 1'b0;
		return r;
	endfunction

	task automatic send_request(input stim_row_t r);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= r.cmd;
		req_ch.char_code <= r.code;
		req_ch.pattern <= r.pat;
		req_ch.pattern_len <= r.len;
		do @(posedge clk); while (!req_ch.ready);
		if (r.cmd == CMD_LOAD)
			load_symbol(r.code, r.pat, r.len);
		else if (r.n_units >= 0)
			expect_units(r.n_units, r.keys, r.brk);
		else
			expect_char(r.code);
	endtask

	initial begin : timeout_guard
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : keying_sink
		int stall;
		key_unit_t got;
		key_unit_t want;
		unit_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				unit_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			unit_ch.ready <= 1'b1;
			do @(posedge clk); while (!unit_ch.valid);
			got.key_on = unit_ch.key_on;
			got.line_break = unit_ch.line_break;
			got.last_unit = unit_ch.last_unit;
			if (pending_units.size() == 0) begin
				$error("unexpected keying unit: key_on %0b line_break %0b last_unit %0b",
					got.key_on, got.line_break, got.last_unit);
				error_count++;
			end else begin
				want = pending_units.pop_front();
				if (got.key_on !== want.key_on) begin
					$error("key_on mismatch: expected %0b, got %0b", want.key_on, got.key_on);
					error_count++;
				end
				if (got.line_break !== want.line_break) begin
					$error("line_break mismatch: expected %0b, got %0b",
						want.line_break, got.line_break);
					error_count++;
				end
				if (got.last_unit !== want.last_unit) begin
					$error("last_unit mismatch: expected %0b, got %0b",
						want.last_unit, got.last_unit);
					error_count++;
				end
			end
		end
	end

	initial begin : request_source
		int sent;
		int n_words;
		int n_enc;
		int pick;
		bit paused;
		int word_codes [$];
		stim_row_t r;

		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_LOAD;
		req_ch.char_code <= '0;
		req_ch.pattern <= '0;
		req_ch.pattern_len <= '0;
		for (int i = 0; i < DEF_TABLE_ENTRIES; i++)
			sym_entries[i] = '0;

		// cleared table, out-of-range bytes, newline, space
		add_row(CMD_ENCODE, 65, 0, 0, 2, 22'h0, 1'b0);
		add_row(CMD_ENCODE, 0, 31, 7, 2, 22'h0, 1'b0);
		add_row(CMD_ENCODE, 127, 0, 0, 2, 22'h0, 1'b0);
		add_row(CMD_ENCODE, 128, 0, 0, 2, 22'h0, 1'b0);
		add_row(CMD_ENCODE, 255, 31, 7, 2, 22'h0, 1'b0);
		add_row(CMD_ENCODE, int'(CHAR_NEWLINE), 0, 0, 1, 22'h0, 1'b1);
		add_row(CMD_ENCODE, int'(CHAR_SPACE), 0, 0, 4, 22'h0, 1'b0);
		// saturated length, all dahs, all dits, single dah
		add_row(CMD_LOAD, 65, 31, 7, 0, 22'h0, 1'b0);
		add_row(CMD_ENCODE, 65, 0, 0, 22, 22'h077777, 1'b0);
		add_row(CMD_LOAD, 69, 0, 5, 0, 22'h0, 1'b0);
		add_row(CMD_ENCODE, 69, 0, 0, 12, 22'h000155, 1'b0);
		add_row(CMD_LOAD, 66, 1, 1, 0, 22'h0, 1'b0);
		add_row(CMD_ENCODE, 66, 0, 0, 6, 22'h000007, 1'b0);
		// table ends
		add_row(CMD_LOAD, 0, 5'b10101, 3, 0, 22'h0, 1'b0);
		add_row(CMD_ENCODE, 0, 0, 0, -1, 22'h0, 1'b0);
		add_row(CMD_LOAD, 127, 5'b01010, 4, 0, 22'h0, 1'b0);
		add_row(CMD_ENCODE, 127, 0, 0, -1, 22'h0, 1'b0);
		// load past the table is dropped
		add_row(CMD_LOAD, 200, 31, 5, 0, 22'h0, 1'b0);
		add_row(CMD_ENCODE, 200, 0, 0, 2, 22'h0, 1'b0);
		// newline and space ignore their table entries
		add_row(CMD_LOAD, int'(CHAR_NEWLINE), 31, 5, 0, 22'h0, 1'b0);
		add_row(CMD_ENCODE, int'(CHAR_NEWLINE), 0, 0, 1, 22'h0, 1'b1);
		add_row(CMD_LOAD, int'(CHAR_SPACE), 31, 5, 0, 22'h0, 1'b0);
		add_row(CMD_ENCODE, int'(CHAR_SPACE), 0, 0, 4, 22'h0, 1'b0);
		// zero length clears an entry
		add_row(CMD_LOAD, 65, 31, 0, 0, 22'h0, 1'b0);
		add_row(CMD_ENCODE, 65, 0, 0, 2, 22'h0, 1'b0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i]);

		sent = 0;
		paused = 1'b0;
		while (sent < RANDOM_REQUESTS) begin
			quiet = ($urandom_range(0, 3) == 0);
			if (!paused && sent >= RANDOM_REQUESTS / 2) begin
				paused = 1'b1;
				req_ch.valid <= 1'b0;
				while (pending_units.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			if ($urandom_range(0, 9) < 7) begin
				// word: load a few characters, then encode them mixed with separators and random bytes
				word_codes.delete();
				n_words = $urandom_range(1, 3);
				repeat (n_words) begin
					r = make_row(CMD_LOAD, $urandom_range(0, 127), $urandom_range(0, 31),
						$urandom_range(0, 7));
					word_codes.push_back(int'(r.code));
					send_request(r);
					sent++;
				end
				n_enc = $urandom_range(2, 6);
				repeat (n_enc) begin
					pick = $urandom_range(0, 9);
					if (pick == 0)
						r = make_row(CMD_ENCODE, int'(CHAR_NEWLINE), $urandom_range(0, 31),
							$urandom_range(0, 7));
					else if (pick == 1)
						r = make_row(CMD_ENCODE, int'(CHAR_SPACE), $urandom_range(0, 31),
							$urandom_range(0, 7));
					else if (pick == 2)
						r = make_row(CMD_ENCODE, $urandom_range(0, 255), $urandom_range(0, 31),
							$urandom_range(0, 7));
					else
						r = make_row(CMD_ENCODE,
							word_codes[$urandom_range(0, word_codes.size() - 1)],
							$urandom_range(0, 31), $urandom_range(0, 7));
					send_request(r);
					sent++;
				end
			end else begin
				r = make_row(1'($urandom_range(0, 1)), $urandom_range(0, 255),
					$urandom_range(0, 31), $urandom_range(0, 7));
				send_request(r);
				sent++;
			end
		end

		req_ch.valid <= 1'b0;
		while (pending_units.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
